FILE: rtl/ffha_pkg.sv
// Shared constants, codes and types of the first-fit heap allocator.
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;

  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 32;
  localparam int OFF_W      = 32;
  localparam int LEN_W      = 33;
  localparam int TOT_W      = LEN_W + 1;
  localparam int SUM_W      = LEN_W + 2;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_HEAP     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 8'd1;

  localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = 32'd1048576;

  typedef struct packed {
    logic              vld;
    logic              mode;
    logic [ADDR_W-1:0] key;
    logic [CNT_W-1:0]  rem;
    logic              found;
    logic [OFF_W-1:0]  hit_off;
  } tok_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    logic             is_free;
  } rec_t;

endpackage

FILE: rtl/ffha_cfg_if.sv
// Configuration write channel: one beat writes one register.
interface ffha_cfg_if;
  import ffha_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ffha_req_if.sv
// Request channel: one beat carries one allocate or free request.
interface ffha_req_if;
  import ffha_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, output mode, output request_size, output block_address,
                  input ready);
  modport sink (input valid, input mode, input request_size, input block_address,
                output ready);
endinterface

FILE: rtl/ffha_rsp_if.sv
// Result channel: one beat carries one granted address and status.
interface ffha_rsp_if;
  import ffha_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic [STAT_W-1:0] status;

  modport source (output valid, output address, output status, input ready);
  modport sink (input valid, input address, input status, output ready);
endinterface

FILE: rtl/ffha_cell.sv
// One block record of the table with its stage of the search token path.
module ffha_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  ffha_pkg::tok_t tok_i,
  output ffha_pkg::tok_t tok_o,
  input  logic          shift_en,
  input  ffha_pkg::rec_t rec_i,
  output ffha_pkg::rec_t rec_o
);
  import ffha_pkg::*;

  rec_t rec_r, rec_nxt;
  tok_t tok_r, tok_nxt;
  logic live;
  logic match;
  logic hit;

  assign live = tok_i.vld && (tok_i.rem != '0);

  always_comb begin
    if (tok_i.mode == MODE_ALLOC) begin
      match = rec_r.is_free && (rec_r.len >= tok_i.key[LEN_W-1:0]);
    end else begin
      match = ({{(ADDR_W-OFF_W){1'b0}}, rec_r.off} == tok_i.key);
    end
  end

  assign hit = live && !tok_i.found && match;

  always_comb begin
    tok_nxt = tok_i;
    if (live) begin
      tok_nxt.rem = tok_i.rem - CNT_W'(1);
    end
    if (hit) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.hit_off = rec_r.off;
    end
  end

  always_comb begin
    rec_nxt = rec_r;
    if (shift_en) begin
      rec_nxt = rec_i;
    end else if (hit) begin
      rec_nxt.is_free = (tok_i.mode == MODE_FREE);
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign rec_o = rec_r;
endmodule

FILE: rtl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: request control and the row of record cells.
// One request is handled at a time. An allocate or a non-null free sends a search token
// down the row of MAX_BLOCKS record cells, newest record first, one cell per cycle; its
// result is loaded into the output register after the token has left the last cell, so
// the length of the cell row, not the number of records, sets when it is ready. A free of
// address zero skips the row and goes straight to the result state. A new request is taken
// in the cycle after the previous result has been loaded into the output register, even
// while that result still waits there; a result that is still not taken when the next
// search ends holds that search until the output register is free. Configuration writes
// are taken in any cycle and must only be issued while the block is idle.
module first_fit_heap_allocator_top (
  input  logic clk,
  input  logic rst_n,
  ffha_cfg_if.sink   cfg_ch,
  ffha_req_if.sink   in_ch,
  ffha_rsp_if.source out_ch
);
  import ffha_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] heap_base_r;
  logic [SIZE_W-1:0] heap_bytes_r;
  logic [CNT_W-1:0]  block_count_r, block_count_nxt;
  logic [LEN_W-1:0]  bump_r, bump_nxt;
  logic [LEN_W-1:0]  size_r, size_nxt;
  logic [TOT_W-1:0]  total_r;
  logic              fits_r;
  tok_t              tok_r, tok_nxt;
  tok_t              fin_tok_r, fin_tok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  logic              acc;
  logic              cfg_acc;
  logic              out_load;
  logic              table_full;
  logic              bump_new;
  logic              grant;
  logic [OFF_W-1:0]  grant_off;
  logic              shift_en;
  rec_t              rec_new;

  tok_t              tok_w [0:MAX_BLOCKS];
  rec_t              rec_w [0:MAX_BLOCKS-1];
  logic [MAX_BLOCKS:0] tok_vld;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign acc          = in_ch.valid && in_ch.ready;

  assign tok_w[0]   = tok_r;
  assign tok_vld[0] = tok_r.vld;

  for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
    if (j == 0) begin : g_head
      ffha_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_i    (tok_w[j]),
        .tok_o    (tok_w[j+1]),
        .shift_en (shift_en),
        .rec_i    (rec_new),
        .rec_o    (rec_w[j])
      );
    end else begin : g_body
      ffha_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_i    (tok_w[j]),
        .tok_o    (tok_w[j+1]),
        .shift_en (shift_en),
        .rec_i    (rec_w[j-1]),
        .rec_o    (rec_w[j])
      );
    end
    assign tok_vld[j+1] = tok_w[j+1].vld;
  end

  assign rec_new.off     = bump_r[OFF_W-1:0];
  assign rec_new.len     = size_r;
  assign rec_new.is_free = 1'b0;

  assign table_full = (block_count_r == CNT_W'(MAX_BLOCKS));
  assign out_load   = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign bump_new   = (fin_tok_r.mode == MODE_ALLOC) && !fin_tok_r.found && fits_r &&
                      !table_full;
  assign shift_en   = out_load && bump_new;
  assign grant      = (fin_tok_r.mode == MODE_ALLOC) && (fin_tok_r.found || bump_new);
  assign grant_off  = fin_tok_r.found ? fin_tok_r.hit_off : bump_r[OFF_W-1:0];

  always_comb begin
    size_nxt = (LEN_W'(in_ch.request_size) + LEN_W'(7)) & ~LEN_W'(7);
  end

  always_comb begin
    state_nxt       = state_r;
    tok_nxt         = tok_r;
    tok_nxt.vld     = 1'b0;
    fin_tok_nxt     = fin_tok_r;
    block_count_nxt = block_count_r;
    bump_nxt        = bump_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_addr_nxt    = out_addr_r;
    out_status_nxt  = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_ch.mode == MODE_FREE && in_ch.block_address == '0) begin
            fin_tok_nxt       = '0;
            fin_tok_nxt.mode  = MODE_FREE;
            fin_tok_nxt.found = 1'b1;
            state_nxt         = S_FIN;
          end else begin
            tok_nxt.vld     = 1'b1;
            tok_nxt.mode    = in_ch.mode;
            tok_nxt.rem     = block_count_r;
            tok_nxt.found   = 1'b0;
            tok_nxt.hit_off = '0;
            if (in_ch.mode == MODE_ALLOC) begin
              tok_nxt.key = ADDR_W'(size_nxt);
            end else begin
              tok_nxt.key = in_ch.block_address - heap_base_r - ADDR_W'(HEADER_BYTES);
            end
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tok_w[MAX_BLOCKS].vld) begin
          fin_tok_nxt = tok_w[MAX_BLOCKS];
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = grant ?
                          (heap_base_r + ADDR_W'(grant_off) + ADDR_W'(HEADER_BYTES)) : '0;
          if (fin_tok_r.mode == MODE_ALLOC) begin
            if (fin_tok_r.found) begin
              out_status_nxt = ST_OK;
            end else if (!fits_r) begin
              out_status_nxt = ST_HEAP;
            end else if (table_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_OK;
            end
          end else begin
            out_status_nxt = fin_tok_r.found ? ST_OK : ST_NOTFOUND;
          end
          if (bump_new) begin
            block_count_nxt = block_count_r + CNT_W'(1);
            bump_nxt        = LEN_W'(TOT_W'(bump_r) + total_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tok_r         <= '0;
      block_count_r <= '0;
      bump_r        <= '0;
      out_valid_r   <= 1'b0;
      heap_base_r   <= '0;
      heap_bytes_r  <= HEAP_BYTES_RST;
    end else begin
      state_r       <= state_nxt;
      tok_r         <= tok_nxt;
      block_count_r <= block_count_nxt;
      bump_r        <= bump_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_acc) begin
        if (cfg_ch.index == CFG_HEAP_BASE) begin
          heap_base_r <= cfg_ch.data[ADDR_W-1:0];
        end else if (cfg_ch.index == CFG_HEAP_BYTES) begin
          heap_bytes_r <= cfg_ch.data[SIZE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_tok_r    <= fin_tok_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    if (acc) begin
      size_r <= size_nxt;
    end
    if (state_r == S_SCAN) begin
      total_r <= TOT_W'(size_r) + TOT_W'(HEADER_BYTES);
      fits_r  <= (SUM_W'(bump_r) + SUM_W'(total_r)) <= SUM_W'(heap_bytes_r);
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.address = out_addr_r;
  assign out_ch.status  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    block_count_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count exceeds the table size");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld) <= 1)
    else $error("more than one search token in the cell row");

  a_shift_only_append: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |-> (state_r == S_FIN && fin_tok_r.mode == MODE_ALLOC && !fin_tok_r.found))
    else $error("record row shifted outside a bump allocation");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_status_nxt == ST_FULL) |-> table_full)
    else $error("table full reported with free records left");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r != S_IDLE))
    else $error("request beat did not start any work");
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench of the first-fit heap allocator with a built-in allocation model.
module tb;
  import ffha_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [LEN_W-1:0] GRAIN = LEN_W'(7);

  typedef struct {
    logic              mode;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] ptr;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [STAT_W-1:0] status;
  } grant_t;

  typedef enum {RX_OPEN, RX_COIN, RX_RUNS} rx_style_e;

  logic clk = 1'b0;
  logic rst_n;

  ffha_cfg_if cfg_if ();
  ffha_req_if in_if ();
  ffha_rsp_if out_if ();

  first_fit_heap_allocator_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  request_t request_q[$];
  grant_t   grant_q[$];
  int       err_count = 0;

  logic [ADDR_W-1:0] heap_base_m;
  logic [SIZE_W-1:0] heap_bytes_m;
  logic [OFF_W-1:0]  rec_off  [MAX_BLOCKS];
  logic [LEN_W-1:0]  rec_len  [MAX_BLOCKS];
  logic              rec_free [MAX_BLOCKS];
  int                rec_count;
  logic [LEN_W-1:0]  bump_m;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] data_address(int idx);
    return heap_base_m + ADDR_W'(rec_off[idx]) + ADDR_W'(HEADER_BYTES);
  endfunction

  function automatic grant_t predict_grant(request_t rq);
    grant_t           g;
    logic [LEN_W-1:0] size;
    logic [63:0]      new_end;
    int               idx;
    bit               hit;
    g.address = '0;
    g.status  = ST_OK;
    hit       = 1'b0;
    if (rq.mode == MODE_ALLOC) begin
      size = (LEN_W'(rq.size) + GRAIN) & ~GRAIN;
      for (idx = rec_count - 1; idx >= 0 && !hit; idx--) begin
        if (rec_free[idx] && rec_len[idx] >= size) begin
          rec_free[idx] = 1'b0;
          g.address     = data_address(idx);
          hit           = 1'b1;
        end
      end
      if (!hit) begin
        new_end = 64'(bump_m) + 64'(HEADER_BYTES) + 64'(size);
        if (new_end > 64'(heap_bytes_m)) begin
          g.status = ST_HEAP;
        end else if (rec_count >= MAX_BLOCKS) begin
          g.status = ST_FULL;
        end else begin
          rec_off[rec_count]  = bump_m[OFF_W-1:0];
          rec_len[rec_count]  = size;
          rec_free[rec_count] = 1'b0;
          g.address           = data_address(rec_count);
          rec_count++;
          bump_m = new_end[LEN_W-1:0];
        end
      end
    end else if (rq.ptr != '0) begin
      for (idx = rec_count - 1; idx >= 0 && !hit; idx--) begin
        if (data_address(idx) == rq.ptr) begin
          rec_free[idx] = 1'b1;
          hit           = 1'b1;
        end
      end
      if (!hit)
        g.status = ST_NOTFOUND;
    end
    return g;
  endfunction

  request_t acc_rq;
  request_t next_rq;
  int       burst_left;
  int       gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        acc_rq.mode = in_if.mode;
        acc_rq.size = in_if.request_size;
        acc_rq.ptr  = in_if.block_address;
        grant_q.push_back(predict_grant(acc_rq));
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0 || request_q.size() == 0) begin
          if (gap_left > 0)
            gap_left--;
          in_if.valid <= 1'b0;
        end else begin
          next_rq = request_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.mode          <= next_rq.mode;
          in_if.request_size  <= next_rq.size;
          in_if.block_address <= next_rq.ptr;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1, 2:    gap_left = $urandom_range(1, 8);
              default: gap_left = $urandom_range(9, 90);
            endcase
          end
        end
      end
    end
  end

  grant_t    want;
  rx_style_e rx_style;
  int        style_left;
  int        run_left;
  bit        rx_hold;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_style   = RX_OPEN;
      style_left = 0;
      run_left   = 0;
      rx_hold    = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (grant_q.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected: address %h status %0d",
                   $time, out_if.address, out_if.status);
        end else begin
          want = grant_q.pop_front();
          if (out_if.address !== want.address) begin
            err_count++;
            $display("%0t: address mismatch: expected %h, actual %h",
                     $time, want.address, out_if.address);
          end
          if (out_if.status !== want.status) begin
            err_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_if.status);
          end
        end
      end
      if (style_left == 0) begin
        rx_style   = rx_style_e'($urandom_range(0, 2));
        style_left = $urandom_range(100, 600);
      end
      style_left--;
      case (rx_style)
        RX_OPEN: out_if.ready <= 1'b1;
        RX_COIN: out_if.ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if (run_left == 0) begin
            rx_hold  = !rx_hold;
            run_left = rx_hold ? $urandom_range(1, 15) : $urandom_range(1, 4);
          end
          run_left--;
          out_if.ready <= !rx_hold;
        end
      endcase
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic push_req(logic mode, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] ptr);
    request_t rq;
    while (request_q.size() >= 2)
      @(posedge clk);
    rq.mode = mode;
    rq.size = size;
    rq.ptr  = ptr;
    request_q.push_back(rq);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_if.valid || grant_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_HEAP_BASE:  heap_base_m  = value[ADDR_W-1:0];
      CFG_HEAP_BYTES: heap_bytes_m = value[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_random(int count);
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] ptr;
    int                pick;
    int                idx;
    repeat (count) begin
      size = $urandom;
      ptr  = ADDR_W'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0)
        wait_idle();
      if (pick < 45) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          size = $urandom_range(0, 64);
        end else if (pick < 75) begin
          size = $urandom_range(0, 1024);
        end else if (pick < 85) begin
          size = $urandom_range(0, 65536);
        end else if (pick < 92 && rec_count > 0) begin
          idx  = $urandom_range(0, rec_count - 1);
          size = rec_len[idx][SIZE_W-1:0] - SIZE_W'($urandom_range(0, 7));
        end
        push_req(MODE_ALLOC, size, ptr);
      end else if (pick < 85 && rec_count > 0) begin
        idx = $urandom_range(0, rec_count - 1);
        push_req(MODE_FREE, size, data_address(idx));
      end else if (pick < 90) begin
        push_req(MODE_FREE, size, '0);
      end else if (pick < 95 && rec_count > 0) begin
        idx = $urandom_range(0, rec_count - 1);
        push_req(MODE_FREE, size, data_address(idx) + ADDR_W'(8));
      end else begin
        push_req(MODE_FREE, size, ptr);
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.mode          = MODE_ALLOC;
    in_if.request_size  = '0;
    in_if.block_address = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_HEAP_BASE;
    cfg_if.data         = '0;
    heap_base_m         = '0;
    heap_bytes_m        = HEAP_BYTES_RST;
    rec_count           = 0;
    bump_m              = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Null and unknown frees, a header-only block, an oversized request, then
    // double free and newest-first reuse of small blocks at known addresses.
    push_req(MODE_FREE, '0, '0);
    push_req(MODE_FREE, '1, '1);
    push_req(MODE_ALLOC, '0, '1);
    push_req(MODE_ALLOC, '1, '0);
    push_req(MODE_ALLOC, 32'd1, '0);
    push_req(MODE_ALLOC, 32'd8, '0);
    push_req(MODE_FREE, '0, 48'd80);
    push_req(MODE_FREE, '0, 48'd80);
    push_req(MODE_ALLOC, 32'd7, '0);
    push_req(MODE_FREE, '0, 48'd48);
    push_req(MODE_FREE, '0, 48'd24);
    push_req(MODE_ALLOC, '0, '0);
    push_req(MODE_ALLOC, 32'd9, '0);
    push_req(MODE_ALLOC, '0, '0);
    push_req(MODE_FREE, '1, 48'd81);
    run_random(80);
    wait_idle();

    // The heap is sized so that the next bump fits exactly and the one after it does not.
    write_reg(CFG_HEAP_BASE, CFG_DATA_W'(48'hFFFF_FFFF_FFF0));
    write_reg(CFG_HEAP_BYTES, CFG_DATA_W'(bump_m) + CFG_DATA_W'(HEADER_BYTES) +
                              CFG_DATA_W'(32'h2_0000));
    push_req(MODE_ALLOC, 32'h2_0000, '0);
    push_req(MODE_ALLOC, 32'h1_FFF9, '0);
    wait_idle();
    write_reg(CFG_HEAP_BYTES, '0);
    run_random(110);
    wait_idle();

    write_reg(CFG_HEAP_BASE, '1);
    write_reg(CFG_HEAP_BYTES, CFG_DATA_W'(32'hFFFF_FFFF));
    push_req(MODE_ALLOC, 32'h8000_0000, '0);
    push_req(MODE_ALLOC, '1, '0);
    repeat (200) begin
      if (rec_count < MAX_BLOCKS)
        push_req(MODE_ALLOC, SIZE_W'($urandom_range(0, 64)), '0);
    end
    push_req(MODE_ALLOC, 32'd4096, '0);
    run_random(150);
    wait_idle();

    write_reg(CFG_HEAP_BASE, CFG_DATA_W'({$urandom, $urandom}));
    write_reg(CFG_HEAP_BYTES, '1);
    run_random(150);
    wait_idle();

    write_reg(CFG_HEAP_BASE, '0);
    write_reg(CFG_HEAP_BYTES, CFG_DATA_W'($urandom));
    run_random(150);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    err_count += grant_q.size();
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ffha_pkg.sv
rtl/ffha_cfg_if.sv
rtl/ffha_req_if.sv
rtl/ffha_rsp_if.sv
rtl/ffha_cell.sv
rtl/first_fit_heap_allocator_top.sv
tb/sv/tb.sv
